[rtl/column_statistics_engine_top_macros.svh]
`ifndef COLUMN_STATISTICS_ENGINE_TOP_MACROS_SVH
`define COLUMN_STATISTICS_ENGINE_TOP_MACROS_SVH
// Assertion helpers
`define CSE_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("%m: implication failed");
`define CSE_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("%m: next-cycle check failed");
`endif

[rtl/cse_pkg.sv]
package cse_pkg;
    localparam int SampleW = 24;
    localparam int IndexW  = 4;
    localparam int CfgW    = 5;
endpackage

[rtl/cse_ram.sv]
module cse_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/cse_divsqrt.sv]
// Shared multicycle unit: restoring unsigned divide, then bit-pair square root.
module cse_divsqrt #(
    parameter int NW = 64,
    parameter int DW = 17
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          go_div,
    input  logic          go_sqrt,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] result
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, rem_reg, x_reg, res_reg, bit_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          div_busy_reg, sqrt_busy_reg, done_reg;

    logic [NW:0]   rem_sh;
    logic [NW-1:0] trial;

    assign rem_sh = {rem_reg, q_reg[NW-1]};
    assign trial  = res_reg + bit_reg;
    assign done   = done_reg;
    assign result = sqrt_busy_reg ? res_reg : q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg  <= 1'b0;
            sqrt_busy_reg <= 1'b0;
            done_reg      <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go_div)
            begin
                div_busy_reg  <= 1'b1;
                sqrt_busy_reg <= 1'b0;
                q_reg         <= num;
                rem_reg       <= '0;
                den_reg       <= den;
                cnt_reg       <= CW'(NW);
            end
            else if (go_sqrt)
            begin
                sqrt_busy_reg <= 1'b1;
                div_busy_reg  <= 1'b0;
                x_reg         <= num;
                res_reg       <= '0;
                bit_reg       <= NW'(1) << (NW - 2);
            end
            else if (div_busy_reg)
            begin
                if (rem_sh >= (NW+1)'(den_reg))
                begin
                    rem_reg <= NW'(rem_sh - (NW+1)'(den_reg));
                    q_reg   <= {q_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= NW'(rem_sh);
                    q_reg   <= {q_reg[NW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    div_busy_reg <= 1'b0;
                    done_reg     <= 1'b1;
                end
            end
            else if (sqrt_busy_reg && !done_reg)
            begin
                if (bit_reg == '0)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    if (x_reg >= trial)
                    begin
                        x_reg   <= x_reg - trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
            end
            else if (done_reg)
            begin
                sqrt_busy_reg <= sqrt_busy_reg;
            end
        end
    end
endmodule

[rtl/column_statistics_engine_top.sv]
// Column statistics engine.
// Config: cfg_valid/cfg_ready/cfg_data writes the column count (0 acts as 1,
// above MAX_COLUMNS acts as MAX_COLUMNS); latched at a table's first element.
// Input: a sample transaction is taken when start is high and busy is low.
// Each element is stored, then a completed row is folded into the per-column
// min/max/sum; busy stays high until this is done. Rows beyond MAX_ROWS are
// dropped and flagged; an incomplete last row is ignored. On the element
// flagged end_of_table the block goes busy and for each column runs: a divide
// of the sum, a pass over the stored rows (one RAM read a cycle, one
// multiply), a second divide and a square root. One result per column is
// shown for one cycle with result_valid; the receiver cannot stall. With no
// rows all statistics are zero and table_empty is set. Reset clears all table
// state; the sample RAM is not cleared, only rows written in the current
// table are read.
module column_statistics_engine_top #(
    parameter int MAX_COLUMNS  = 16,
    parameter int MAX_ROWS     = 1024,
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cse_pkg::CfgW-1:0]        cfg_data,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [SAMPLE_WIDTH-1:0]  sample_value,
    input  logic                            end_of_table,
    output logic                            result_valid,
    output logic [cse_pkg::IndexW-1:0]      column_index,
    output logic signed [SAMPLE_WIDTH-1:0]  column_min,
    output logic signed [SAMPLE_WIDTH-1:0]  column_max,
    output logic signed [SAMPLE_WIDTH-1:0]  column_mean,
    output logic [SAMPLE_WIDTH-1:0]         column_std_dev,
    output logic                            rows_dropped,
    output logic                            table_empty,
    output logic                            last_column
);
    import cse_pkg::*;

    localparam int CW   = $clog2(MAX_COLUMNS) > 0 ? $clog2(MAX_COLUMNS) : 1;
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int RCW  = $clog2(MAX_ROWS + 1);
    localparam int AW   = RW + CW;
    localparam int SUMW = SAMPLE_WIDTH + RCW + 1;
    localparam int NW   = 64;
    localparam int CNTW = $clog2(MAX_COLUMNS + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_UPD   = 8'b0000_0010,
        S_DIV1  = 8'b0000_0100,
        S_W1    = 8'b0000_1000,
        S_PASS  = 8'b0001_0000,
        S_W2    = 8'b0010_0000,
        S_SQRT  = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } state_t;

    state_t state_reg;

    logic [CNTW-1:0] cfg_reg, act_reg, eff_cols;
    logic [CW-1:0]   pos_reg, col_reg;
    logic [RCW-1:0]  rows_reg, rd_reg;
    logic            ovf_reg, last_reg;
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [SAMPLE_WIDTH-1:0] row_reg [MAX_COLUMNS];
    logic signed [SAMPLE_WIDTH-1:0] row_val [MAX_COLUMNS];
    logic signed [SAMPLE_WIDTH-1:0] min_reg [MAX_COLUMNS];
    logic signed [SAMPLE_WIDTH-1:0] max_reg [MAX_COLUMNS];
    logic signed [SUMW-1:0]         sum_reg [MAX_COLUMNS];
    logic signed [SUMW-1:0]         mean_reg;
    logic [NW-1:0]                  sq_reg;
    logic [2*SAMPLE_WIDTH+1:0]      prod_reg;
    logic                           prod_v_reg, rd_v_reg;
    logic [SAMPLE_WIDTH-1:0]        dev_reg;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [SAMPLE_WIDTH-1:0] ram_rdata;

    logic                 go_div, go_sqrt, du_done;
    logic [NW-1:0]        du_num, du_res;
    logic                 first_elem;
    logic [CNTW-1:0]      pos_use;
    logic signed [SUMW:0] dif;
    logic [SAMPLE_WIDTH:0] mag;
    logic [SUMW-1:0]      sum_abs;

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != S_IDLE);

    always_comb
    begin
        if (cfg_reg == '0)
            eff_cols = CNTW'(1);
        else if (cfg_reg > CNTW'(MAX_COLUMNS))
            eff_cols = CNTW'(MAX_COLUMNS);
        else
            eff_cols = cfg_reg;
    end

    assign first_elem = (rows_reg == '0) && (pos_reg == '0) && !ovf_reg;

    // Storage address uses the wrapped position and current row.
    always_comb
    begin
        pos_use = (first_elem ? eff_cols : act_reg);
        if (CNTW'(pos_reg) >= pos_use)
            pos_use = '0;
        else
            pos_use = CNTW'(pos_reg);
    end

    // current row: earlier columns from the row buffer, this element direct
    always_comb
    begin
        for (int i = 0; i < MAX_COLUMNS; i++)
        begin
            row_val[i] = (CW'(i) == pos_reg) ? x_reg : row_reg[i];
        end
    end

    assign ram_we    = start && !busy && (rows_reg < RCW'(MAX_ROWS));
    assign ram_waddr = {rows_reg[RW-1:0], pos_use[CW-1:0]};
    assign ram_raddr = {rd_reg[RW-1:0], col_reg};

    cse_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(1 << AW)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (sample_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign sum_abs  = sum_reg[col_reg][SUMW-1] ? SUMW'(-sum_reg[col_reg])
                                               : SUMW'(sum_reg[col_reg]);
    assign go_div   = (state_reg == S_DIV1 && rows_reg != '0)
                      || (state_reg == S_PASS && !rd_v_reg && !prod_v_reg
                          && rd_reg == rows_reg && last_reg);
    assign du_num   = (state_reg == S_DIV1) ? NW'(sum_abs) : sq_reg;
    assign go_sqrt  = (state_reg == S_W2) && du_done;

    cse_divsqrt #(.NW(NW), .DW(RCW)) u_du (
        .clk     (clk),
        .rst_n   (rst_n),
        .go_div  (go_div),
        .go_sqrt (go_sqrt),
        .num     (go_sqrt ? du_res : du_num),
        .den     (rows_reg),
        .done    (du_done),
        .result  (du_res)
    );

    // |sample - mean| stays below 2^SAMPLE_WIDTH
    assign dif = (SUMW+1)'($signed(ram_rdata)) - (SUMW+1)'(mean_reg);
    assign mag = dif[SUMW] ? (SAMPLE_WIDTH+1)'(-dif) : (SAMPLE_WIDTH+1)'(dif);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cfg_reg      <= CNTW'(1);
            act_reg      <= CNTW'(1);
            pos_reg      <= '0;
            rows_reg     <= '0;
            ovf_reg      <= 1'b0;
            last_reg     <= 1'b0;
            col_reg      <= '0;
            rd_reg       <= '0;
            prod_v_reg   <= 1'b0;
            rd_v_reg     <= 1'b0;
            result_valid <= 1'b0;
            for (int i = 0; i < MAX_COLUMNS; i++)
            begin
                min_reg[i] <= '0;
                max_reg[i] <= '0;
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            result_valid <= 1'b0;
            if (cfg_valid)
            begin
                cfg_reg <= (cfg_data > CfgW'(MAX_COLUMNS)) ? CNTW'(MAX_COLUMNS)
                           : CNTW'(cfg_data);
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        if (first_elem)
                            act_reg <= eff_cols;
                        pos_reg   <= pos_use[CW-1:0];
                        x_reg     <= sample_value;
                        last_reg  <= end_of_table;
                        state_reg <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    row_reg[pos_reg] <= x_reg;
                    if (pos_reg == CW'(act_reg - 1'b1))
                    begin
                        if (rows_reg < RCW'(MAX_ROWS))
                        begin
                            rows_reg <= rows_reg + 1'b1;
                            // only a completed row enters the running stats
                            for (int i = 0; i < MAX_COLUMNS; i++)
                            begin
                                if (CNTW'(i) < act_reg)
                                begin
                                    if (rows_reg == '0 || row_val[i] < min_reg[i])
                                        min_reg[i] <= row_val[i];
                                    if (rows_reg == '0 || row_val[i] > max_reg[i])
                                        max_reg[i] <= row_val[i];
                                    sum_reg[i] <= sum_reg[i] + SUMW'(row_val[i]);
                                end
                            end
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        pos_reg <= '0;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + 1'b1;
                    end
                    col_reg   <= '0;
                    state_reg <= last_reg ? S_DIV1 : S_IDLE;
                end
                S_DIV1:
                begin
                    last_reg  <= 1'b0;
                    state_reg <= (rows_reg == '0) ? S_EMIT : S_W1;
                end
                S_W1:
                begin
                    if (du_done)
                    begin
                        mean_reg   <= sum_reg[col_reg][SUMW-1]
                                      ? -SUMW'(du_res) : SUMW'(du_res);
                        sq_reg     <= '0;
                        rd_reg     <= '0;
                        rd_v_reg   <= 1'b0;
                        prod_v_reg <= 1'b0;
                        state_reg  <= S_PASS;
                    end
                end
                S_PASS:
                begin
                    rd_v_reg   <= (rd_reg != rows_reg);
                    if (rd_reg != rows_reg)
                        rd_reg <= rd_reg + 1'b1;
                    prod_v_reg <= rd_v_reg;
                    prod_reg   <= mag * mag;
                    if (prod_v_reg)
                        sq_reg <= sq_reg + NW'(prod_reg);
                    if (rd_reg == rows_reg && !rd_v_reg && !prod_v_reg)
                    begin
                        if (last_reg)
                            state_reg <= S_W2;
                        else
                            last_reg <= 1'b1;
                    end
                end
                S_W2:
                begin
                    last_reg <= 1'b0;
                    if (du_done)
                        state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (du_done)
                    begin
                        dev_reg   <= SAMPLE_WIDTH'(du_res);
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    result_valid   <= 1'b1;
                    column_index   <= IndexW'(col_reg);
                    column_min     <= (rows_reg == '0) ? '0 : min_reg[col_reg];
                    column_max     <= (rows_reg == '0) ? '0 : max_reg[col_reg];
                    column_mean    <= (rows_reg == '0) ? '0
                                      : SAMPLE_WIDTH'(mean_reg);
                    column_std_dev <= (rows_reg == '0) ? '0 : dev_reg;
                    rows_dropped   <= ovf_reg;
                    table_empty    <= (rows_reg == '0);
                    last_column    <= (CNTW'(col_reg) == act_reg - 1'b1);
                    if (CNTW'(col_reg) == act_reg - 1'b1)
                    begin
                        state_reg <= S_IDLE;
                        rows_reg  <= '0;
                        pos_reg   <= '0;
                        ovf_reg   <= 1'b0;
                        for (int i = 0; i < MAX_COLUMNS; i++)
                        begin
                            min_reg[i] <= '0;
                            max_reg[i] <= '0;
                            sum_reg[i] <= '0;
                        end
                    end
                    else
                    begin
                        col_reg   <= col_reg + 1'b1;
                        state_reg <= S_DIV1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `include "column_statistics_engine_top_macros.svh"

    `CSE_ASSERT_IMPL(a_result_only_busy, clk, rst_n, result_valid, busy || $past(busy))
    `CSE_ASSERT_NEXT(a_start_goes_busy, clk, rst_n, start && !busy, busy)
    `CSE_ASSERT_IMPL(a_empty_zero, clk, rst_n, result_valid && table_empty, column_std_dev == '0)
endmodule
